[rtl/core/lcdseq_pkg.sv]
// ----------------------------------------------------------------------------
// lcdseq_pkg: shared types and constants of the character LCD sequencer
// Holds the command codes, controller byte values, wait times, the job
// record passed from the front end to the back end, and the init table.
// ----------------------------------------------------------------------------
package lcdseq_pkg;

  // Default geometry of the panel
  localparam int DEF_COLUMNS = 16;
  localparam int DEF_ROWS    = 2;

  // Depth of the queues between the parts
  localparam int QUEUE_DEPTH = 2;

  // Command codes of an input item
  localparam logic [2:0] CMD_INIT      = 3'd0;
  localparam logic [2:0] CMD_PUTC      = 3'd1;
  localparam logic [2:0] CMD_CLEAR     = 3'd2;
  localparam logic [2:0] CMD_HOME      = 3'd3;
  localparam logic [2:0] CMD_SETCUR    = 3'd4;
  localparam logic [2:0] CMD_BACKLIGHT = 3'd5;
  localparam logic [2:0] CMD_DISPLAY   = 3'd6;

  // Special characters
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_RETURN  = 8'h0D;

  // Controller command bytes
  localparam logic [7:0] LCD_CLS      = 8'h01;
  localparam logic [7:0] LCD_HOME     = 8'h02;
  localparam logic [7:0] LCD_DISP_ON  = 8'h0C;
  localparam logic [7:0] LCD_DISP_OFF = 8'h08;
  localparam logic [7:0] LCD_DDRAM    = 8'h80;

  // Expander bit positions
  localparam int BIT_RS = 0;
  localparam int BIT_EN = 2;
  localparam int BIT_BL = 3;

  // Wait times in microseconds
  localparam logic [14:0] WAIT_POWER = 15'd20000;
  localparam logic [14:0] WAIT_SET   = 15'd0;
  localparam logic [14:0] WAIT_EN    = 15'd2;
  localparam logic [14:0] WAIT_NORM  = 15'd50;
  localparam logic [14:0] WAIT_4500  = 15'd4550;
  localparam logic [14:0] WAIT_150   = 15'd200;
  localparam logic [14:0] WAIT_2000  = 15'd2050;

  // Extra pause after the EN-low byte of a nibble
  localparam logic [1:0] EXT_NONE = 2'd0;
  localparam logic [1:0] EXT_4500 = 2'd1;
  localparam logic [1:0] EXT_150  = 2'd2;
  localparam logic [1:0] EXT_2000 = 2'd3;

  // Job kinds
  localparam logic [1:0] JOB_INIT   = 2'd0;
  localparam logic [1:0] JOB_SEND   = 2'd1;
  localparam logic [1:0] JOB_ONE    = 2'd2;
  localparam logic [1:0] JOB_REJECT = 2'd3;

  // Nibble phases
  localparam logic [1:0] PH_SET  = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  // Last nibble index of the init run
  localparam logic [3:0] INIT_LAST_NIB = 4'd13;

  // Work handed from the front end to the back end
  typedef struct packed {
    logic [1:0] kind;
    logic       bl;
    logic       has_first;
    logic [7:0] first_val;
    logic [7:0] main_val;
    logic       main_rs;
    logic       main_long;
  } lcdseq_job_t;

  // One result item
  typedef struct packed {
    logic [7:0]  expander_byte;
    logic [14:0] wait_after_us;
    logic        rejected;
    logic        last;
  } lcdseq_res_t;

  // One nibble of the init run
  typedef struct packed {
    logic [3:0] data;
    logic [1:0] ext;
  } lcdseq_nib_t;

  // Init run after the power byte: four lone nibbles, then five commands
  function automatic lcdseq_nib_t init_nibble(input logic [3:0] idx);
    lcdseq_nib_t n;
    n.ext = EXT_NONE;
    unique case (idx)
      4'd0:    n.data = 4'h3;
      4'd1:    n.data = 4'h3;
      4'd2:    n.data = 4'h3;
      4'd3:    n.data = 4'h2;
      4'd4:    n.data = 4'h2;
      4'd5:    n.data = 4'h8;
      4'd6:    n.data = 4'h0;
      4'd7:    n.data = 4'h8;
      4'd8:    n.data = 4'h0;
      4'd9:    n.data = 4'h1;
      4'd10:   n.data = 4'h0;
      4'd11:   n.data = 4'h6;
      4'd12:   n.data = 4'h0;
      4'd13:   n.data = 4'hC;
      default: n.data = 4'h0;
    endcase
    if (idx == 4'd0) begin
      n.ext = EXT_4500;
    end else if (idx <= 4'd3) begin
      n.ext = EXT_150;
    end else if (idx == 4'd9) begin
      n.ext = EXT_2000;
    end
    return n;
  endfunction

  // Wait after one byte of a nibble
  function automatic logic [14:0] nibble_wait(input logic [1:0] phase,
                                              input logic [1:0] ext);
    logic [14:0] w;
    if (phase == PH_SET) begin
      w = WAIT_SET;
    end else if (phase == PH_HIGH) begin
      w = WAIT_EN;
    end else begin
      unique case (ext)
        EXT_NONE: w = WAIT_NORM;
        EXT_4500: w = WAIT_4500;
        EXT_150:  w = WAIT_150;
        EXT_2000: w = WAIT_2000;
        default:  w = WAIT_NORM;
      endcase
    end
    return w;
  endfunction

endpackage

[rtl/core/lcdseq_fifo.sv]
// ----------------------------------------------------------------------------
// lcdseq_fifo: small first-in first-out queue
// Registered storage with separate full and empty flags; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module lcdseq_fifo #(
  parameter type item_t = logic [7:0],
  parameter int  DEPTH  = lcdseq_pkg::QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t din,
  output logic  full,
  input  logic  pop,
  output item_t dout,
  output logic  empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

[rtl/core/lcdseq_front.sv]
// ----------------------------------------------------------------------------
// lcdseq_front: command decoder and cursor tracker
// Classifies each accepted item, keeps cursor and backlight state, and
// turns the item into a job for the byte sequencer.
// ----------------------------------------------------------------------------
module lcdseq_front #(
  parameter int COLUMNS = lcdseq_pkg::DEF_COLUMNS,
  parameter int ROWS    = lcdseq_pkg::DEF_ROWS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  logic [2:0]               cmd,
  input  logic [7:0]               char_code,
  input  logic [7:0]               target_col,
  input  logic [7:0]               target_row,
  input  logic                     switch_on,
  output lcdseq_pkg::lcdseq_job_t  job
);
  import lcdseq_pkg::*;

  localparam int COL_W = $clog2(COLUMNS + 1);

  logic [COL_W-1:0] col_r, col_nxt;
  logic             row_r, row_nxt;
  logic             bl_r, bl_nxt;
  logic             wrap_row;
  logic [7:0]       nl_byte, cr_byte, set_byte;
  logic [6:0]       set_addr;
  logic             set_bad;

  // Row reached by a newline or a line wrap
  assign wrap_row = (ROWS > 1) ? ~row_r : 1'b0;

  // Cursor command bytes, column zero unless set explicitly
  assign nl_byte  = LCD_DDRAM | {1'b0, wrap_row, 6'b0};
  assign cr_byte  = LCD_DDRAM | {1'b0, row_r, 6'b0};
  assign set_addr = {target_row[0], 6'b0} + {1'b0, target_col[5:0]};
  assign set_byte = LCD_DDRAM | {1'b0, set_addr};
  assign set_bad  = (target_col >= 8'(COLUMNS)) || (target_row >= 8'(ROWS));

  // Classify the item and work out the state it leaves
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    bl_nxt        = bl_r;
    job           = '0;
    job.kind      = JOB_SEND;
    job.bl        = bl_r;
    unique case (cmd)
      CMD_INIT: begin
        job.kind = JOB_INIT;
        job.bl   = 1'b1;
        bl_nxt   = 1'b1;
        col_nxt  = '0;
        row_nxt  = 1'b0;
      end
      CMD_PUTC: begin
        if (char_code == CHAR_NEWLINE) begin
          job.main_val = nl_byte;
          col_nxt      = '0;
          row_nxt      = wrap_row;
        end else if (char_code == CHAR_RETURN) begin
          job.main_val = cr_byte;
          col_nxt      = '0;
        end else begin
          job.main_val = char_code;
          job.main_rs  = 1'b1;
          if (col_r >= COL_W'(COLUMNS)) begin
            // Full line: move to the start of the next row first
            job.has_first = 1'b1;
            job.first_val = nl_byte;
            row_nxt       = wrap_row;
            col_nxt       = COL_W'(1);
          end else begin
            col_nxt = col_r + 1'b1;
          end
        end
      end
      CMD_CLEAR, CMD_HOME: begin
        job.main_val  = (cmd == CMD_CLEAR) ? LCD_CLS : LCD_HOME;
        job.main_long = 1'b1;
        col_nxt       = '0;
        row_nxt       = 1'b0;
      end
      CMD_SETCUR: begin
        if (set_bad) begin
          job.kind = JOB_REJECT;
        end else begin
          job.main_val = set_byte;
          col_nxt      = COL_W'(target_col);
          row_nxt      = target_row[0];
        end
      end
      CMD_BACKLIGHT: begin
        job.kind = JOB_ONE;
        job.bl   = switch_on;
        bl_nxt   = switch_on;
      end
      CMD_DISPLAY: begin
        job.main_val = switch_on ? LCD_DISP_ON : LCD_DISP_OFF;
      end
      default: begin
        job.kind = JOB_REJECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= 1'b0;
      bl_r  <= 1'b0;
    end else if (take) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      bl_r  <= bl_nxt;
    end
  end

endmodule

[rtl/core/lcdseq_back.sv]
// ----------------------------------------------------------------------------
// lcdseq_back: expander byte sequencer
// Expands one job at a time into bytes, one per cycle unless the result
// queue is full, and loads the next job in the cycle the current one ends.
// ----------------------------------------------------------------------------
module lcdseq_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lcdseq_pkg::lcdseq_job_t  job,
  input  logic                     job_avail,
  output logic                     job_take,
  output lcdseq_pkg::lcdseq_res_t  res,
  output logic                     res_push,
  input  logic                     res_full
);
  import lcdseq_pkg::*;

  lcdseq_job_t cur_r, cur_nxt;
  logic        busy_r, busy_nxt;
  logic        pre_r, pre_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  nib_r, nib_nxt;

  lcdseq_nib_t init_nib;
  logic [7:0]  src;
  logic        is_main;
  logic [3:0]  data;
  logic        rs;
  logic [1:0]  ext;
  logic [3:0]  last_nib;
  logic [7:0]  nib_byte;
  logic        job_end;

  // Source of the current nibble
  always_comb begin
    init_nib = init_nibble(nib_r);
    is_main  = !(cur_r.has_first && !nib_r[1]);
    src      = is_main ? cur_r.main_val : cur_r.first_val;
    if (cur_r.kind == JOB_INIT) begin
      data     = init_nib.data;
      rs       = 1'b0;
      ext      = init_nib.ext;
      last_nib = INIT_LAST_NIB;
    end else begin
      data     = nib_r[0] ? src[3:0] : src[7:4];
      rs       = is_main && cur_r.main_rs;
      ext      = (is_main && nib_r[0] && cur_r.main_long) ? EXT_2000 : EXT_NONE;
      last_nib = cur_r.has_first ? 4'd3 : 4'd1;
    end
    nib_byte          = {data, 4'b0};
    nib_byte[BIT_RS]  = rs;
    nib_byte[BIT_BL]  = cur_r.bl;
    nib_byte[BIT_EN]  = (phase_r == PH_HIGH);
  end

  // Byte for this cycle and whether it ends the job
  always_comb begin
    res     = '0;
    job_end = 1'b0;
    unique case (cur_r.kind)
      JOB_INIT: begin
        if (pre_r) begin
          res.expander_byte         = 8'h00;
          res.expander_byte[BIT_BL] = cur_r.bl;
          res.wait_after_us         = WAIT_POWER;
        end else begin
          res.expander_byte = nib_byte;
          res.wait_after_us = nibble_wait(phase_r, ext);
          job_end           = (phase_r == PH_LOW) && (nib_r == last_nib);
        end
      end
      JOB_SEND: begin
        res.expander_byte = nib_byte;
        res.wait_after_us = nibble_wait(phase_r, ext);
        job_end           = (phase_r == PH_LOW) && (nib_r == last_nib);
      end
      JOB_ONE: begin
        res.expander_byte         = 8'h00;
        res.expander_byte[BIT_BL] = cur_r.bl;
        res.wait_after_us         = WAIT_SET;
        job_end                   = 1'b1;
      end
      JOB_REJECT: begin
        res.rejected = 1'b1;
        job_end      = 1'b1;
      end
      default: begin
        job_end = 1'b1;
      end
    endcase
    res.last = job_end && (cur_r.kind != JOB_REJECT);
  end

  assign res_push = busy_r && !res_full;
  assign job_take = job_avail && (!busy_r || (res_push && job_end));

  // Step through the job, or load the next one
  always_comb begin
    cur_nxt   = cur_r;
    busy_nxt  = busy_r;
    pre_nxt   = pre_r;
    phase_nxt = phase_r;
    nib_nxt   = nib_r;
    if (res_push) begin
      if (pre_r) begin
        pre_nxt = 1'b0;
      end else if (phase_r == PH_LOW) begin
        phase_nxt = PH_SET;
        nib_nxt   = nib_r + 1'b1;
      end else begin
        phase_nxt = phase_r + 1'b1;
      end
      if (job_end) begin
        busy_nxt = 1'b0;
      end
    end
    if (job_take) begin
      cur_nxt   = job;
      busy_nxt  = 1'b1;
      pre_nxt   = (job.kind == JOB_INIT);
      phase_nxt = PH_SET;
      nib_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      pre_r   <= 1'b0;
      phase_r <= PH_SET;
      nib_r   <= '0;
    end else begin
      busy_r  <= busy_nxt;
      pre_r   <= pre_nxt;
      phase_r <= phase_nxt;
      nib_r   <= nib_nxt;
    end
  end

  // The job record is payload
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

endmodule

[rtl/core/char_lcd_i2c_expander_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// char_lcd_i2c_expander_sequencer_unit: character LCD command sequencer
// Turns LCD commands into the expander bytes of a 4-bit panel interface,
// each tagged with the wait that must follow it.
// ----------------------------------------------------------------------------
//  Channel  | Handshake     | Item
//  ---------+---------------+-----------------------------------------------
//  in_      | push / full   | cmd, char_code, target_col, target_row,
//           |               | switch_on
//  out_     | pop / empty   | expander_byte, wait_after_us, rejected, last
//
// The back sequencer sends one expander byte per cycle while the result
// queue has room. An accepted item passes the job queue and the job register
// of the sequencer, and its result the result queue, before it shows on the
// outputs. Reset clears the cursor, backlight and both queues at once; there
// is no clearing pass. A two-entry job queue lets new items be accepted
// while the sequencer works or the output stalls.
// ----------------------------------------------------------------------------
module char_lcd_i2c_expander_sequencer_unit #(
  parameter int COLUMNS = lcdseq_pkg::DEF_COLUMNS,
  parameter int ROWS    = lcdseq_pkg::DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_target_col,
  input  logic [7:0]  in_target_row,
  input  logic        in_switch_on,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_expander_byte,
  output logic [14:0] out_wait_after_us,
  output logic        out_rejected,
  output logic        out_last
);
  import lcdseq_pkg::*;

  lcdseq_job_t front_job, queued_job;
  lcdseq_res_t back_res, head_res;
  logic        take;
  logic        jq_empty, job_take;
  logic        res_push, res_full;

  assign take = in_push && !in_full;

  // Decoder and cursor tracking
  lcdseq_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .cmd        (in_cmd),
    .char_code  (in_char_code),
    .target_col (in_target_col),
    .target_row (in_target_row),
    .switch_on  (in_switch_on),
    .job        (front_job)
  );

  // Job queue between the front end and the sequencer
  lcdseq_fifo #(
    .item_t (lcdseq_job_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (front_job),
    .full  (in_full),
    .pop   (job_take),
    .dout  (queued_job),
    .empty (jq_empty)
  );

  // Byte sequencer
  lcdseq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (queued_job),
    .job_avail (!jq_empty),
    .job_take  (job_take),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // Result queue towards the expander link
  lcdseq_fifo #(
    .item_t (lcdseq_res_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (back_res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (head_res),
    .empty (out_empty)
  );

  assign out_expander_byte = head_res.expander_byte;
  assign out_wait_after_us = head_res.wait_after_us;
  assign out_rejected      = head_res.rejected;
  assign out_last          = head_res.last;

endmodule

[rtl/core/lcdseq_checker.sv]
// ----------------------------------------------------------------------------
// lcdseq_checker: port-level checks of the LCD sequencer
// Watches the result channel for malformed items and attaches itself to the
// top level through a bind statement.
// ----------------------------------------------------------------------------
module lcdseq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [7:0]  out_expander_byte,
  input logic [14:0] out_wait_after_us,
  input logic        out_rejected,
  input logic        out_last
);

  // A refused command carries no byte, no wait and no end mark.
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_rejected) |->
      (out_expander_byte == 8'h00 && out_wait_after_us == 15'd0 && !out_last))
    else $error("refused item carries data");

  // The EN-high byte of a nibble is always followed by the short strobe wait.
  a_strobe_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_rejected && out_expander_byte[2]) |->
      (out_wait_after_us == 15'd2))
    else $error("EN-high byte with wrong wait");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present after reset");

  // A stalled result stays in place.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=>
      (!out_empty && $stable(out_expander_byte) && $stable(out_wait_after_us)
       && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind char_lcd_i2c_expander_sequencer_unit lcdseq_checker u_lcdseq_checker (.*);

[bench/lcd_byte_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_byte_check: result checker of the character LCD sequencer
// Watches both queue ports of the sequencer. For every command item taken in,
// it works out the expander bytes and waits that the panel driver must emit,
// keeping its own cursor and backlight state. Every result item popped is
// compared field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module lcd_byte_check #(
  parameter int COLUMNS = lcdseq_pkg::DEF_COLUMNS,
  parameter int ROWS    = lcdseq_pkg::DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [2:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_target_col,
  input  logic [7:0]  in_target_row,
  input  logic        in_switch_on,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [7:0]  out_expander_byte,
  input  logic [14:0] out_wait_after_us,
  input  logic        out_rejected,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count
);
  import lcdseq_pkg::*;

  // Controller bytes of the start-up run, and the address offset of row one
  localparam logic [7:0] LCD_FUNC_4BIT = 8'h28;
  localparam logic [7:0] LCD_ENTRY_INC = 8'h06;
  localparam logic [7:0] ROW1_OFFSET   = 8'h40;

  // Expected panel state
  logic [5:0] cursor_col;
  logic       cursor_row;
  logic       lamp_on;

  // Expander bytes still owed by the sequencer, oldest first
  lcdseq_res_t expected_bytes[$];
  int          mismatches;

  initial begin
    cursor_col    = '0;
    cursor_row    = 1'b0;
    lamp_on       = 1'b0;
    mismatches    = 0;
    fail_count    = 0;
    pending_count = 0;
  end

  // One expander byte; the backlight bit follows the current state.
  function automatic void owe_byte(input logic [7:0] value, input logic [14:0] wait_us);
    lcdseq_res_t r;
    r.expander_byte = value;
    if (lamp_on) begin
      r.expander_byte[BIT_BL] = 1'b1;
    end
    r.wait_after_us = wait_us;
    r.rejected      = 1'b0;
    r.last          = 1'b0;
    expected_bytes.push_back(r);
  endfunction

  // One nibble: set, EN high, EN low; any long pause rides on the EN-low wait.
  function automatic void owe_nibble(input logic [3:0] data, input logic rs,
                                     input logic [14:0] low_wait);
    logic [7:0] v;
    v = {data, 4'b0000};
    v[BIT_RS] = rs;
    owe_byte(v, WAIT_SET);
    v[BIT_EN] = 1'b1;
    owe_byte(v, WAIT_EN);
    v[BIT_EN] = 1'b0;
    owe_byte(v, low_wait);
  endfunction

  // A full controller byte goes out high nibble first.
  function automatic void owe_lcd_byte(input logic [7:0] value, input logic rs,
                                       input logic [14:0] low_wait);
    owe_nibble(value[7:4], rs, WAIT_NORM);
    owe_nibble(value[3:0], rs, low_wait);
  endfunction

  function automatic void place_cursor(input logic [5:0] col, input logic row);
    logic [7:0] addr;
    cursor_col = col;
    cursor_row = row;
    addr = ((row ? ROW1_OFFSET : 8'h00) + {2'b00, col}) & 8'h7F;
    owe_lcd_byte(LCD_DDRAM | addr, 1'b0, WAIT_NORM);
  endfunction

  function automatic logic following_row();
    return (ROWS > 1) ? ~cursor_row : 1'b0;
  endfunction

  // Works out every result item that one command causes.
  function automatic void predict_command(input logic [2:0] cmd, input logic [7:0] ch,
                                          input logic [7:0] tcol, input logic [7:0] trow,
                                          input logic on);
    int          first;
    logic        refused;
    lcdseq_res_t r;
    first   = expected_bytes.size();
    refused = 1'b0;
    case (cmd)
      CMD_INIT: begin
        lamp_on = 1'b1;
        owe_byte(8'h00, WAIT_POWER);
        owe_nibble(4'h3, 1'b0, WAIT_4500);
        owe_nibble(4'h3, 1'b0, WAIT_150);
        owe_nibble(4'h3, 1'b0, WAIT_150);
        owe_nibble(4'h2, 1'b0, WAIT_150);
        owe_lcd_byte(LCD_FUNC_4BIT, 1'b0, WAIT_NORM);
        owe_lcd_byte(LCD_DISP_OFF, 1'b0, WAIT_NORM);
        owe_lcd_byte(LCD_CLS, 1'b0, WAIT_2000);
        cursor_col = '0;
        cursor_row = 1'b0;
        owe_lcd_byte(LCD_ENTRY_INC, 1'b0, WAIT_NORM);
        owe_lcd_byte(LCD_DISP_ON, 1'b0, WAIT_NORM);
      end
      CMD_PUTC: begin
        if (ch == CHAR_NEWLINE) begin
          place_cursor('0, following_row());
        end else if (ch == CHAR_RETURN) begin
          place_cursor('0, cursor_row);
        end else begin
          // A full line wraps before the character lands.
          if (cursor_col >= COLUMNS) begin
            place_cursor('0, following_row());
          end
          owe_lcd_byte(ch, 1'b1, WAIT_NORM);
          cursor_col = cursor_col + 6'd1;
        end
      end
      CMD_CLEAR, CMD_HOME: begin
        owe_lcd_byte((cmd == CMD_CLEAR) ? LCD_CLS : LCD_HOME, 1'b0, WAIT_2000);
        cursor_col = '0;
        cursor_row = 1'b0;
      end
      CMD_SETCUR: begin
        if (tcol >= COLUMNS || trow >= ROWS) begin
          refused = 1'b1;
        end else begin
          place_cursor(tcol[5:0], trow[0]);
        end
      end
      CMD_BACKLIGHT: begin
        lamp_on = on;
        owe_byte(8'h00, WAIT_SET);
      end
      CMD_DISPLAY: begin
        owe_lcd_byte(on ? LCD_DISP_ON : LCD_DISP_OFF, 1'b0, WAIT_NORM);
      end
      default: begin
        refused = 1'b1;
      end
    endcase
    // A refused command gives one bare result, with the last flag clear.
    if (refused) begin
      r = '0;
      r.rejected = 1'b1;
      expected_bytes.push_back(r);
    end else if (expected_bytes.size() > first) begin
      expected_bytes[expected_bytes.size() - 1].last = 1'b1;
    end
  endfunction

  // Sample both channels at the clock edge.
  always @(posedge clk) begin
    lcdseq_res_t want;
    if (!rst_n) begin
      cursor_col = '0;
      cursor_row = 1'b0;
      lamp_on    = 1'b0;
      expected_bytes.delete();
    end else begin
      if (in_push && !in_full) begin
        predict_command(in_cmd, in_char_code, in_target_col, in_target_row, in_switch_on);
      end
      if (out_pop && !out_empty) begin
        if (expected_bytes.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: unexpected result item: byte %h wait %0d rej %b last %b",
                     $realtime, out_expander_byte, out_wait_after_us, out_rejected,
                     out_last);
          end
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_expander_byte !== want.expander_byte ||
              out_wait_after_us !== want.wait_after_us ||
              out_rejected !== want.rejected || out_last !== want.last) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch (byte/wait/rej/last): expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                       $realtime, want.expander_byte, want.wait_after_us, want.rejected,
                       want.last, out_expander_byte, out_wait_after_us, out_rejected,
                       out_last);
            end
            mismatches++;
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending_count <= expected_bytes.size();
  end

endmodule

[bench/tb_char_lcd_i2c_expander_sequencer_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_char_lcd_i2c_expander_sequencer_unit: testbench of the LCD sequencer
// Sends a directed set of commands covering start-up, special characters,
// line wrap, refused cursor moves and every command, then a long random mix
// with random gaps on the input and random stalls on the output. A separate
// checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_char_lcd_i2c_expander_sequencer_unit;
  import lcdseq_pkg::*;

  localparam int         COLUMNS      = DEF_COLUMNS;
  localparam int         ROWS         = DEF_ROWS;
  localparam int         RANDOM_ITEMS = 206;
  localparam int         IDLE_LIMIT   = 1000;
  localparam logic [2:0] CMD_RESERVED = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [2:0]  in_cmd;
  logic [7:0]  in_char_code;
  logic [7:0]  in_target_col;
  logic [7:0]  in_target_row;
  logic        in_switch_on;
  logic        out_empty;
  logic        out_pop;
  logic [7:0]  out_expander_byte;
  logic [14:0] out_wait_after_us;
  logic        out_rejected;
  logic        out_last;
  int          fail_count;
  int          pending_count;
  logic        calm;
  int          pop_hold;

  char_lcd_i2c_expander_sequencer_unit #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_cmd            (in_cmd),
    .in_char_code      (in_char_code),
    .in_target_col     (in_target_col),
    .in_target_row     (in_target_row),
    .in_switch_on      (in_switch_on),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_expander_byte (out_expander_byte),
    .out_wait_after_us (out_wait_after_us),
    .out_rejected      (out_rejected),
    .out_last          (out_last)
  );

  lcd_byte_check #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) byte_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_cmd            (in_cmd),
    .in_char_code      (in_char_code),
    .in_target_col     (in_target_col),
    .in_target_row     (in_target_row),
    .in_switch_on      (in_switch_on),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_expander_byte (out_expander_byte),
    .out_wait_after_us (out_wait_after_us),
    .out_rejected      (out_rejected),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_length();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  // Random field values of the input widths
  function automatic logic [7:0] rnd8();
    return 8'($urandom);
  endfunction

  function automatic logic rnd1();
    return 1'($urandom);
  endfunction

  // Offer one command item and hold it until the sequencer takes it.
  task automatic issue_command(input logic [2:0] cmd, input logic [7:0] ch,
                               input logic [7:0] tcol, input logic [7:0] trow,
                               input logic on);
    int n;
    @(negedge clk);
    in_push       <= 1'b1;
    in_cmd        <= cmd;
    in_char_code  <= ch;
    in_target_col <= tcol;
    in_target_row <= trow;
    in_switch_on  <= on;
    do @(posedge clk); while (in_full);
    // Random gap with junk on the fields while push is low
    if (!calm && $urandom_range(0, 2) == 0) begin
      n = gap_length();
      @(negedge clk);
      in_push       <= 1'b0;
      in_cmd        <= 3'($urandom);
      in_char_code  <= rnd8();
      in_target_col <= rnd8();
      in_target_row <= rnd8();
      in_switch_on  <= rnd1();
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Output side: pop with random stalls, none while calm.
  initial begin
    out_pop  = 1'b0;
    pop_hold = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        out_pop <= 1'b0;
        pop_hold--;
      end else begin
        out_pop <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) begin
          pop_hold = gap_length();
        end
      end
    end
  end

  // Ends the run when neither channel moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("char_lcd_i2c_expander_sequencer_unit verification failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int         pick;
    logic [2:0] cmd;
    logic [7:0] ch;
    logic [7:0] tcol;
    logic [7:0] trow;
    logic       on;
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_cmd        = CMD_INIT;
    in_char_code  = '0;
    in_target_col = '0;
    in_target_row = '0;
    in_switch_on  = 1'b0;
    calm          = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: a character before start-up, then every command and corner.
    issue_command(CMD_PUTC, 8'h41, rnd8(), rnd8(), rnd1());
    issue_command(CMD_INIT, rnd8(), rnd8(), rnd8(), rnd1());
    issue_command(CMD_PUTC, 8'h00, rnd8(), rnd8(), rnd1());
    issue_command(CMD_PUTC, 8'hFF, rnd8(), rnd8(), rnd1());
    issue_command(CMD_PUTC, CHAR_NEWLINE, rnd8(), rnd8(), rnd1());
    issue_command(CMD_PUTC, CHAR_NEWLINE, rnd8(), rnd8(), rnd1());
    issue_command(CMD_PUTC, CHAR_RETURN, rnd8(), rnd8(), rnd1());
    // Fill the lower line and wrap back to the top one
    issue_command(CMD_SETCUR, rnd8(), 8'(COLUMNS - 1), 8'(ROWS - 1), rnd1());
    issue_command(CMD_PUTC, 8'h55, rnd8(), rnd8(), rnd1());
    issue_command(CMD_PUTC, 8'hAA, rnd8(), rnd8(), rnd1());
    // Cursor moves outside the panel are refused
    issue_command(CMD_SETCUR, rnd8(), 8'(COLUMNS), 8'd0, rnd1());
    issue_command(CMD_SETCUR, rnd8(), 8'd0, 8'(ROWS), rnd1());
    issue_command(CMD_SETCUR, rnd8(), 8'hFF, 8'hFF, rnd1());
    issue_command(CMD_SETCUR, rnd8(), 8'd0, 8'd0, rnd1());
    issue_command(CMD_RESERVED, rnd8(), rnd8(), rnd8(), rnd1());
    issue_command(CMD_BACKLIGHT, rnd8(), rnd8(), rnd8(), 1'b0);
    issue_command(CMD_DISPLAY, rnd8(), rnd8(), rnd8(), 1'b1);
    issue_command(CMD_DISPLAY, rnd8(), rnd8(), rnd8(), 1'b0);
    issue_command(CMD_BACKLIGHT, rnd8(), rnd8(), rnd8(), 1'b1);
    issue_command(CMD_CLEAR, rnd8(), rnd8(), rnd8(), rnd1());
    issue_command(CMD_HOME, rnd8(), rnd8(), rnd8(), rnd1());
    issue_command(CMD_SETCUR, rnd8(), 8'(COLUMNS - 1), 8'd0, rnd1());
    issue_command(CMD_PUTC, 8'h7E, rnd8(), rnd8(), rnd1());
    issue_command(CMD_PUTC, 8'h31, rnd8(), rnd8(), rnd1());

    // Random part: mostly characters, with cursor moves near the line end so
    // that wraps come often.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 20 == 0) begin
        calm = ($urandom_range(0, 3) == 0);
      end
      ch   = rnd8();
      tcol = rnd8();
      trow = rnd8();
      on   = rnd1();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        cmd = CMD_PUTC;
        case ($urandom_range(0, 19))
          0, 1:    ch = CHAR_NEWLINE;
          2:       ch = CHAR_RETURN;
          default: ;
        endcase
      end else if (pick < 67) begin
        cmd = CMD_SETCUR;
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 1) == 0) begin
            tcol = 8'($urandom_range(COLUMNS - 4, COLUMNS - 1));
          end else begin
            tcol = 8'($urandom_range(0, COLUMNS - 1));
          end
          trow = 8'($urandom_range(0, ROWS - 1));
        end
      end else if (pick < 71) begin
        cmd = CMD_CLEAR;
      end else if (pick < 75) begin
        cmd = CMD_HOME;
      end else if (pick < 82) begin
        cmd = CMD_BACKLIGHT;
      end else if (pick < 89) begin
        cmd = CMD_DISPLAY;
      end else if (pick < 92) begin
        cmd = CMD_INIT;
      end else if (pick < 95) begin
        cmd = CMD_RESERVED;
      end else begin
        cmd = CMD_PUTC;
      end
      issue_command(cmd, ch, tcol, trow, on);
    end

    // Drain, then keep clocking for anything stray.
    calm = 1'b1;
    @(negedge clk);
    in_push <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("char_lcd_i2c_expander_sequencer_unit verification clean");
    end else begin
      $display("char_lcd_i2c_expander_sequencer_unit verification failed");
    end
    $finish;
  end

endmodule

[char_lcd_i2c_expander_sequencer_unit.f]
rtl/core/lcdseq_pkg.sv
rtl/core/lcdseq_fifo.sv
rtl/core/lcdseq_front.sv
rtl/core/lcdseq_back.sv
rtl/core/char_lcd_i2c_expander_sequencer_unit.sv
rtl/core/lcdseq_checker.sv
bench/lcd_byte_check.sv
bench/tb_char_lcd_i2c_expander_sequencer_unit.sv
